// ----- rtl/cap_pkg.sv -----
// Shared constants, types and tables for the complex adder with polar output.
package cap_pkg;

  localparam int IN_W     = 16;   // Q7.8 input parts
  localparam int SUM_W    = 17;   // Q8.8 sum parts
  localparam int V1_W     = 18;   // first result value
  localparam int V2_W     = 17;   // second result value
  localparam int XY_W     = 28;   // CORDIC x and y, 16 fraction bits
  localparam int Z_W      = 28;   // CORDIC angle, 24 fraction bits
  localparam int ATAN_LEN = 24;
  localparam int MAG_W    = XY_W + 31 - 38;  // product bits kept after the 2^-38 scale

  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [Z_W-1:0]  HALF_PI_Z = Z_W'(26353589);
  localparam logic [V2_W-1:0] PI_OUT    = V2_W'(25736);
  localparam logic [30:0]     GAIN_K    = 31'(652032874);
  localparam logic [V1_W-1:0] MAG_MAX   = V1_W'(92682);
  localparam logic [Z_W-1:0]  ANG_ROUND = Z_W'(1024);

  // Output form register codes.
  localparam logic FORM_RECT  = 1'b0;
  localparam logic FORM_POLAR = 1'b1;

  // atan(2^-i) scaled by 2^24, rounded to nearest.
  localparam logic [Z_W-1:0] ATAN_TAB [ATAN_LEN] = '{
    Z_W'(13176795), Z_W'(7778716), Z_W'(4110060), Z_W'(2086331),
    Z_W'(1047214),  Z_W'(524117),  Z_W'(262123),  Z_W'(131069),
    Z_W'(65536),    Z_W'(32768),   Z_W'(16384),   Z_W'(8192),
    Z_W'(4096),     Z_W'(2048),    Z_W'(1024),    Z_W'(512),
    Z_W'(256),      Z_W'(128),     Z_W'(64),      Z_W'(32),
    Z_W'(16),       Z_W'(8),       Z_W'(4),       Z_W'(2)
  };

  // Payload that travels down the CORDIC pipeline.
  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
    logic signed [SUM_W-1:0] sum_re;
    logic signed [SUM_W-1:0] sum_im;
    logic                    polar;
    logic                    zero;
    logic                    neg_axis;
  } cordic_t;

endpackage

// ----- rtl/cap_if.sv -----
// Valid/ready channel interfaces for the input and result items.
interface cap_in_if import cap_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] first_real;
  logic signed [IN_W-1:0] first_imag;
  logic signed [IN_W-1:0] second_real;
  logic signed [IN_W-1:0] second_imag;

  modport source (output valid, first_real, first_imag, second_real, second_imag,
                  input ready);
  modport sink   (input valid, first_real, first_imag, second_real, second_imag,
                  output ready);
endinterface

interface cap_out_if import cap_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [V1_W-1:0] value_one;
  logic signed [V2_W-1:0] value_two;
  logic                   is_polar;

  modport source (output valid, value_one, value_two, is_polar, input ready);
  modport sink   (input valid, value_one, value_two, is_polar, output ready);
endinterface

// ----- rtl/cap_cordic_stage.sv -----
// One registered vectoring iteration of the CORDIC pipeline.
module cap_cordic_stage import cap_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    valid_in,
  input  cordic_t data_in,
  output logic    ready_in,
  output logic    valid_r,
  output cordic_t data_r,
  input  logic    ready_out
);

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  cordic_t                data_nxt;

  assign ready_in = !valid_r || ready_out;

  always_comb begin
    dx       = data_in.y >>> IDX;
    dy       = data_in.x >>> IDX;
    data_nxt = data_in;
    // Rotate toward the positive real axis, steering by the sign of y.
    if (!data_in.y[XY_W-1]) begin
      data_nxt.x = data_in.x + dx;
      data_nxt.y = data_in.y - dy;
      data_nxt.z = data_in.z + ATAN_TAB[IDX];
    end else begin
      data_nxt.x = data_in.x - dx;
      data_nxt.y = data_in.y + dy;
      data_nxt.z = data_in.z - ATAN_TAB[IDX];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_in) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && valid_in) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- rtl/complex_add_to_polar.sv -----
// Top level: complex adder with optional CORDIC rectangular-to-polar output.
//
//  Channel  | Direction | Payload
//  ---------+-----------+----------------------------------------------------
//  in_ch    | sink      | first_real, first_imag, second_real, second_imag
//  out_ch   | source    | value_one, value_two, is_polar
//  cfg_     | write     | cfg_we, cfg_wdata (output form)
//
// An item passes through the fold register (add and quadrant fold), one register per
// CORDIC iteration, the gain register (gain multiply) and the output register.
// One item enters per cycle while out_ch takes results; the rate is set by the iteration pipeline.
// Every stage holds its item while the next one is full and stalled, and empty
// stages fill in behind, so a stall on out_ch loses and repeats nothing.
// Reset clears all valid bits and sets the output form to rectangular.
module complex_add_to_polar import cap_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  cap_in_if.sink          in_ch,
  cap_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic            cfg_wdata
);

  logic form_r;

  // Pipeline registers: index 0 is the fold stage, k+1 follows iteration k.
  logic    pv [CORDIC_STEPS+1];
  cordic_t pd [CORDIC_STEPS+1];
  logic    prdy [CORDIC_STEPS+2];

  // Fold stage.
  logic signed [SUM_W-1:0] sum_re;
  logic signed [SUM_W-1:0] sum_im;
  logic signed [XY_W-1:0]  x0;
  logic signed [XY_W-1:0]  y0;
  cordic_t                 d0_nxt;

  // Gain stage.
  logic                      g_v_r;
  logic signed [MAG_W-1:0]   g_mag_r;
  logic signed [V2_W-1:0]    g_ang_r;
  logic signed [SUM_W-1:0]   g_re_r;
  logic signed [SUM_W-1:0]   g_im_r;
  logic                      g_polar_r;
  logic                      g_zero_r;
  logic                      g_neg_r;
  logic                      g_rdy;
  logic signed [XY_W+30:0]   prod;
  logic signed [Z_W-1:0]     z_rnd;

  // Output stage.
  logic                    o_v_r;
  logic signed [V1_W-1:0]  o_v1_r;
  logic signed [V2_W-1:0]  o_v2_r;
  logic                    o_polar_r;
  logic signed [V1_W-1:0]  v1_nxt;
  logic signed [V2_W-1:0]  v2_nxt;
  logic                    o_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      form_r <= FORM_RECT;
    end else if (cfg_we) begin
      form_r <= cfg_wdata;
    end
  end

  // Add, then fold a left-half-plane vector by a quarter turn.
  always_comb begin
    sum_re = SUM_W'(in_ch.first_real) + SUM_W'(in_ch.second_real);
    sum_im = SUM_W'(in_ch.first_imag) + SUM_W'(in_ch.second_imag);
    x0     = {{(XY_W-SUM_W-8){sum_re[SUM_W-1]}}, sum_re, 8'b0};
    y0     = {{(XY_W-SUM_W-8){sum_im[SUM_W-1]}}, sum_im, 8'b0};
    d0_nxt.sum_re   = sum_re;
    d0_nxt.sum_im   = sum_im;
    d0_nxt.polar    = form_r;
    d0_nxt.zero     = (sum_re == '0) && (sum_im == '0);
    d0_nxt.neg_axis = (sum_im == '0) && sum_re[SUM_W-1];
    d0_nxt.x        = x0;
    d0_nxt.y        = y0;
    d0_nxt.z        = '0;
    if (sum_re[SUM_W-1]) begin
      if (!sum_im[SUM_W-1]) begin
        d0_nxt.x = y0;
        d0_nxt.y = -x0;
        d0_nxt.z = HALF_PI_Z;
      end else begin
        d0_nxt.x = -y0;
        d0_nxt.y = x0;
        d0_nxt.z = -HALF_PI_Z;
      end
    end
  end

  assign prdy[0]     = !pv[0] || prdy[1];
  assign in_ch.ready = prdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv[0] <= 1'b0;
    end else if (prdy[0]) begin
      pv[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prdy[0] && in_ch.valid) begin
      pd[0] <= d0_nxt;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
    cap_cordic_stage #(.IDX(k)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (pv[k]),
      .data_in   (pd[k]),
      .ready_in  (prdy[k+1]),
      .valid_r   (pv[k+1]),
      .data_r    (pd[k+1]),
      .ready_out (prdy[k+2])
    );
  end

  // Gain compensation and angle rounding.
  assign g_rdy                = !g_v_r || o_rdy;
  assign prdy[CORDIC_STEPS+1] = g_rdy;
  assign prod  = pd[CORDIC_STEPS].x * $signed({1'b0, GAIN_K});
  assign z_rnd = pd[CORDIC_STEPS].z + ANG_ROUND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else if (g_rdy) begin
      g_v_r <= pv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (g_rdy && pv[CORDIC_STEPS]) begin
      g_mag_r   <= prod[XY_W+30:38];
      g_ang_r   <= z_rnd[V2_W+10:11];
      g_re_r    <= pd[CORDIC_STEPS].sum_re;
      g_im_r    <= pd[CORDIC_STEPS].sum_im;
      g_polar_r <= pd[CORDIC_STEPS].polar;
      g_zero_r  <= pd[CORDIC_STEPS].zero;
      g_neg_r   <= pd[CORDIC_STEPS].neg_axis;
    end
  end

  // Select and clamp the result values.
  always_comb begin
    if (g_polar_r == FORM_RECT) begin
      v1_nxt = V1_W'(g_re_r);
      v2_nxt = g_im_r;
    end else if (g_zero_r) begin
      v1_nxt = '0;
      v2_nxt = '0;
    end else begin
      if (g_mag_r[MAG_W-1]) begin
        v1_nxt = '0;
      end else if (g_mag_r > $signed({1'b0, MAG_MAX})) begin
        v1_nxt = MAG_MAX;
      end else begin
        v1_nxt = g_mag_r[V1_W-1:0];
      end
      v2_nxt = g_neg_r ? PI_OUT : g_ang_r;
    end
  end

  assign o_rdy = !o_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_rdy) begin
      o_v_r <= g_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy && g_v_r) begin
      o_v1_r    <= v1_nxt;
      o_v2_r    <= v2_nxt;
      o_polar_r <= g_polar_r;
    end
  end

  assign out_ch.valid     = o_v_r;
  assign out_ch.value_one = o_v1_r;
  assign out_ch.value_two = o_v2_r;
  assign out_ch.is_polar  = o_polar_r;

  // A folded item that cannot move on keeps its contents.
  a_fold_hold: assert property (@(posedge clk) disable iff (!rst_n)
    pv[0] && !prdy[1] |=> pv[0] && $stable(pd[0]))
    else $error("fold stage item changed while stalled");

  // A polar angle stays near the range of atan2.
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_polar |->
      out_ch.value_two <= $signed(V2_W'(25736 + 256)) &&
      out_ch.value_two >= $signed(-V2_W'(25736 + 256)))
    else $error("polar angle out of range");

  // No item is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid && !g_v_r)
    else $error("pipeline not empty after reset");

endmodule
